/* design/fabt_pkg.sv */
// Shared types and constants for the failed attempt ban table.
package fabt_pkg;

    localparam logic [1:0] OP_QUERY   = 2'd0;
    localparam logic [1:0] OP_ATTEMPT = 2'd1;
    localparam logic [1:0] OP_PURGE   = 2'd2;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MAX    = 2'd1;
    localparam logic [1:0] CFG_HOURS  = 2'd2;

    localparam int          CFG_WIDTH       = 16;
    localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
    localparam logic [15:0] FIRST_COUNT     = 16'd1;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [7:0]  PURGE_MAX       = 8'd255;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] ip_address;
        logic [31:0] now_seconds;
    } in_beat_t;

    typedef struct packed {
        logic       banned;
        logic       table_full;
        logic [7:0] purged_count;
    } out_beat_t;

endpackage

/* design/failed_attempt_ban_table.sv */
// Failed attempt ban table: top level with sweep sequencer over the entry memories.
//
// Each beat sweeps both tables, one entry per cycle each, through their memories,
// as each table memory has a single read port.
// Valid bits live in flip-flops and are
// cleared at reset, so no clearing pass is needed. The result sits in an output
// register; the next beat is taken once it has been delivered.
module failed_attempt_ban_table #(
    parameter int BAN_ENTRIES     = 64,
    parameter int ATTEMPT_ENTRIES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [fabt_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fabt_pkg::in_beat_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fabt_pkg::out_beat_t         m_data
);
    import fabt_pkg::*;

    localparam int BW = (BAN_ENTRIES > 1) ? $clog2(BAN_ENTRIES) : 1;
    localparam int AW = (ATTEMPT_ENTRIES > 1) ? $clog2(ATTEMPT_ENTRIES) : 1;
    localparam int NMAX = (BAN_ENTRIES > ATTEMPT_ENTRIES) ? BAN_ENTRIES : ATTEMPT_ENTRIES;
    localparam int CW = $clog2(NMAX + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LIMIT = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DEC   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic        en_reg;
    logic [15:0] max_reg;
    logic [13:0] hours_reg;

    logic [2:0]  state_reg, state_next;
    in_beat_t    item_reg;
    logic [31:0] limit_reg;
    logic [CW-1:0] idx_reg;
    logic        rd_valid_reg;
    logic [CW-1:0] rd_idx_reg;

    logic [BAN_ENTRIES-1:0]     ban_valid_reg;
    logic [ATTEMPT_ENTRIES-1:0] att_valid_reg;

    logic        ban_hit_reg, att_hit_reg, ban_free_ok_reg, att_free_ok_reg;
    logic [BW-1:0] ban_free_reg;
    logic [AW-1:0] att_hit_idx_reg, att_free_reg;
    logic [15:0] att_cnt_reg;
    logic [7:0]  purged_reg;
    out_beat_t   out_reg;
    out_beat_t   out_next;
    logic        m_valid_reg;

    logic [BW-1:0] ban_addr;
    logic [AW-1:0] att_addr;
    logic          ban_we, att_we;
    logic [63:0]   ban_wdata, ban_rdata;
    logic [79:0]   att_wdata, att_rdata;

    logic [31:0] b_key, b_stamp, a_key, a_stamp;
    logic [15:0] a_cnt;
    logic        b_in, a_in, b_ok, a_ok;
    logic [BW-1:0] b_i;
    logic [AW-1:0] a_i;
    logic [15:0] cnt_inc;
    logic [1:0]  purge_add;
    logic [8:0]  purge_sum;

    assign {b_key, b_stamp} = ban_rdata;
    assign {a_key, a_cnt, a_stamp} = att_rdata;
    assign b_i = rd_idx_reg[BW-1:0];
    assign a_i = rd_idx_reg[AW-1:0];
    assign b_in = rd_valid_reg && (rd_idx_reg < CW'(BAN_ENTRIES));
    assign a_in = rd_valid_reg && (rd_idx_reg < CW'(ATTEMPT_ENTRIES));
    assign b_ok = b_in && ban_valid_reg[b_i];
    assign a_ok = a_in && att_valid_reg[a_i];
    assign cnt_inc = (att_cnt_reg == COUNT_MAX) ? COUNT_MAX : att_cnt_reg + 16'd1;

    fabt_ram #(.WIDTH(64), .DEPTH(BAN_ENTRIES)) u_ban_ram (
        .aclk(aclk), .we(ban_we), .addr(ban_addr), .wdata(ban_wdata), .rdata(ban_rdata)
    );
    fabt_ram #(.WIDTH(80), .DEPTH(ATTEMPT_ENTRIES)) u_att_ram (
        .aclk(aclk), .we(att_we), .addr(att_addr), .wdata(att_wdata), .rdata(att_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // decisions made after the sweep
    logic do_ban, do_att_new, do_att_upd, do_att_drop;
    always_comb begin
        do_ban = 1'b0;
        do_att_new = 1'b0;
        do_att_upd = 1'b0;
        do_att_drop = 1'b0;
        if (en_reg && item_reg.operation == OP_ATTEMPT && !ban_hit_reg) begin
            if (!att_hit_reg) begin
                do_att_new = att_free_ok_reg;
            end else if (cnt_inc >= max_reg) begin
                do_att_drop = 1'b1;
                do_ban = ban_free_ok_reg;
            end else begin
                do_att_upd = 1'b1;
            end
        end
    end

    always_comb begin
        out_next = '0;
        if (item_reg.operation == OP_PURGE) begin
            out_next.purged_count = purged_reg;
        end else if (en_reg && item_reg.operation == OP_QUERY) begin
            out_next.banned = ban_hit_reg;
        end else if (en_reg && item_reg.operation == OP_ATTEMPT) begin
            if (ban_hit_reg) begin
                out_next.banned = 1'b1;
            end else if (!att_hit_reg) begin
                out_next.table_full = !att_free_ok_reg;
            end else if (cnt_inc >= max_reg) begin
                out_next.banned     = 1'b1;
                out_next.table_full = !ban_free_ok_reg;
            end
        end
    end

    always_comb begin
        ban_addr  = idx_reg[BW-1:0];
        att_addr  = idx_reg[AW-1:0];
        ban_we    = 1'b0;
        att_we    = 1'b0;
        ban_wdata = {item_reg.ip_address, item_reg.now_seconds};
        att_wdata = {item_reg.ip_address, FIRST_COUNT, item_reg.now_seconds};
        if (state_reg == ST_WRITE) begin
            ban_addr = ban_free_reg;
            ban_we   = do_ban;
            if (do_att_upd) begin
                att_addr  = att_hit_idx_reg;
                att_we    = 1'b1;
                att_wdata = {item_reg.ip_address, cnt_inc, item_reg.now_seconds};
            end else begin
                att_addr = att_free_reg;
                att_we   = do_att_new;
            end
        end
    end

    always_comb begin
        purge_add = {1'b0, b_ok && (item_reg.now_seconds - b_stamp > limit_reg)}
                  + {1'b0, a_ok && (item_reg.now_seconds - a_stamp > limit_reg)};
        purge_sum = {1'b0, purged_reg} + {7'd0, purge_add};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid && s_ready) state_next = ST_LIMIT;
            ST_LIMIT: state_next = ST_SCAN;
            ST_SCAN:  if (idx_reg == CW'(NMAX - 1)) state_next = ST_DEC;
            ST_DEC:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            en_reg        <= 1'b0;
            max_reg       <= 16'd10;
            hours_reg     <= 14'd1;
            ban_valid_reg <= '0;
            att_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENABLE: en_reg    <= cfg_data[0];
                    CFG_MAX:    max_reg   <= cfg_data;
                    CFG_HOURS:  hours_reg <= cfg_data[13:0];
                    default:    ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            rd_valid_reg <= (state_reg == ST_SCAN);
            rd_idx_reg   <= idx_reg;

            case (state_reg)
                ST_IDLE: begin
                    item_reg        <= s_data;
                    idx_reg         <= '0;
                    ban_hit_reg     <= 1'b0;
                    att_hit_reg     <= 1'b0;
                    ban_free_ok_reg <= 1'b0;
                    att_free_ok_reg <= 1'b0;
                    purged_reg      <= '0;
                end
                ST_LIMIT: limit_reg <= 32'(hours_reg * SECONDS_PER_HOUR);
                ST_SCAN, ST_DEC: begin
                    if (state_reg == ST_SCAN) idx_reg <= idx_reg + CW'(1);
                    if (b_in && !ban_valid_reg[b_i] && !ban_free_ok_reg) begin
                        ban_free_ok_reg <= 1'b1;
                        ban_free_reg    <= b_i;
                    end
                    if (a_in && !att_valid_reg[a_i] && !att_free_ok_reg) begin
                        att_free_ok_reg <= 1'b1;
                        att_free_reg    <= a_i;
                    end
                    if (b_ok && b_key == item_reg.ip_address) ban_hit_reg <= 1'b1;
                    if (a_ok && a_key == item_reg.ip_address) begin
                        att_hit_reg     <= 1'b1;
                        att_hit_idx_reg <= a_i;
                        att_cnt_reg     <= a_cnt;
                    end
                    if (item_reg.operation == OP_PURGE) begin
                        if (b_ok && (item_reg.now_seconds - b_stamp > limit_reg))
                            ban_valid_reg[b_i] <= 1'b0;
                        if (a_ok && (item_reg.now_seconds - a_stamp > limit_reg))
                            att_valid_reg[a_i] <= 1'b0;
                        purged_reg <= (purge_sum > {1'b0, PURGE_MAX}) ? PURGE_MAX
                                                                      : purge_sum[7:0];
                    end
                end
                ST_WRITE: begin
                    out_reg <= out_next;
                    if (do_att_new) att_valid_reg[att_free_reg] <= 1'b1;
                    if (do_att_drop) att_valid_reg[att_hit_idx_reg] <= 1'b0;
                    if (do_ban) ban_valid_reg[ban_free_reg] <= 1'b1;
                end
                ST_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

/* design/fabt_ram.sv */
// Generic single-port RAM with registered read.
module fabt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
